### rtl/core/kea_pkg.sv
`default_nettype none
package kea_pkg;

	localparam int MAX_CENTERS = 16;
	localparam int MAX_SAMPLES = 4096;
	localparam int CIDX_W      = $clog2(MAX_CENTERS);
	localparam int SIDX_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = $clog2(MAX_CENTERS + 1);

	localparam int COORD_W = 16;
	localparam int WGT_W   = 16;
	localparam int DIST_W  = 17;
	localparam int D2_W    = 34;
	localparam int SQ_W    = 2 * COORD_W;
	localparam int WD_W    = 50;
	localparam int OBJ_W   = 62;
	localparam int CWT_W   = 28;
	localparam int SUM_W   = 44;
	localparam int ACT_W   = 5;

	localparam int ROW_W = MAX_CENTERS * DIST_W;
	localparam int MEM_W = CIDX_W + ROW_W;

	localparam logic [2:0] FN_CENTER  = 3'd0;
	localparam logic [2:0] FN_PAIR    = 3'd1;
	localparam logic [2:0] FN_MINHALF = 3'd2;
	localparam logic [2:0] FN_START   = 3'd3;
	localparam logic [2:0] FN_ASSIGN  = 3'd4;
	localparam logic [2:0] FN_READ    = 3'd5;

	typedef struct packed {
		logic [2:0]         func;
		logic [11:0]        sidx;
		logic [3:0]         center_a;
		logic [3:0]         center_b;
		logic [COORD_W-1:0] coord_r;
		logic [COORD_W-1:0] coord_g;
		logic [COORD_W-1:0] coord_b;
		logic [DIST_W-1:0]  hdist;
		logic [WGT_W-1:0]   weight;
	} in_word_t;

	typedef struct packed {
		logic [3:0]        membership;
		logic [DIST_W-1:0] upper_bound;
		logic [DIST_W-1:0] lower_bound;
		logic [WD_W-1:0]   weighted_distance;
		logic [OBJ_W-1:0]  objective;
		logic [CWT_W-1:0]  cluster_weight;
		logic [SUM_W-1:0]  cluster_sum_r;
		logic [SUM_W-1:0]  cluster_sum_g;
		logic [SUM_W-1:0]  cluster_sum_b;
	} out_word_t;

	typedef struct packed {
		logic              done;
		logic [DIST_W-1:0] root;
	} isqrt_stat_t;

endpackage
`default_nettype wire

### rtl/core/kea_ram.sv
`default_nettype none
module kea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/kea_isqrt.sv
`default_nettype none
module kea_isqrt import kea_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [D2_W-1:0] value,
	output isqrt_stat_t          stat
);

	localparam int STEPS = D2_W / 2;
	localparam int STP_W = $clog2(STEPS);
	localparam int REM_W = DIST_W + 2;

	logic             busy_q;
	logic             done_q;
	logic [STP_W-1:0] cnt_q;
	logic [D2_W-1:0]  val_q;
	logic [REM_W-1:0] rem_q;
	logic [DIST_W-1:0] root_q;

	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic             ge;
	logic [REM_W+1:0] rem_nx;

	// one result bit per step, classic digit-by-digit root
	assign rem_sh = {rem_q, val_q[D2_W-1 -: 2]};
	assign trial  = {{(REM_W - DIST_W){1'b0}}, root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign rem_nx = ge ? rem_sh - trial : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= STP_W'(STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[D2_W-3:0], 2'b00};
			rem_q  <= rem_nx[REM_W-1:0];
			root_q <= {root_q[DIST_W-2:0], ge};
		end
	end

	assign stat.done = done_q;
	assign stat.root = root_q;

endmodule
`default_nettype wire

### rtl/core/kmeans_elkan_assign.sv
// channel | dir | handshake         | word
// in      | in  | in_valid/in_stall | in_word_t: command and sample
// out     | out | out_valid/out_stall | out_word_t: one result per command
// cfg     | in  | cfg_we            | cfg_wdata: active center count
//
// One command at a time: writes, start and read execute and emit; a zero-weight assign
// also passes the row read. Assign adds the lower-bound scan and 4 weight products,
// plus, per computed distance, 3 channel squares, a start and a bit-serial root,
// and a pair check per center visited when the minimum half distance does not prune.
// Reset runs a clearing pass over all 4096 entries of the sample store, in_stall high.
// A stalled result holds; the next command is taken while it waits.
`default_nettype none
module kmeans_elkan_assign import kea_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_word_t         in_word,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_word_t             out_word,
	input  wire logic             cfg_we,
	input  wire logic [ACT_W-1:0] cfg_wdata
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_EXEC, S_ROW, S_DIST, S_SQST, S_SQRT,
		S_PAIR, S_CHK, S_LOW, S_MUL, S_ACC, S_EMIT
	} state_t;

	state_t state_q;

	in_word_t  in_q;
	out_word_t res_q;
	out_word_t out_word_q;
	logic      out_valid_q;

	logic [ACT_W-1:0]  active_q;
	logic [SIDX_W-1:0] clr_q;
	logic [CIDX_W-1:0] c_q;
	logic [CIDX_W-1:0] best_q;
	logic [1:0]        ch_q;
	logic [1:0]        mi_q;
	logic              first_q;
	logic [DIST_W-1:0] upper_q;
	logic [DIST_W:0]   lower_q;
	logic [OBJ_W-1:0]  objective_q;
	logic [CWT_W-1:0]  cw_q [MAX_CENTERS];
	logic [SUM_W-1:0]  sum_q [MAX_CENTERS][3];

	logic [COORD_W-1:0] center_q [MAX_CENTERS][3];
	logic [DIST_W-1:0]  minh_q [MAX_CENTERS];
	logic [MAX_CENTERS-1:0][DIST_W-1:0] row_q;
	logic [D2_W-1:0]    acc_q;
	logic [D2_W-1:0]    d2_q;
	logic [D2_W-1:0]    best_d2_q;
	logic [WD_W-1:0]    wd_q;
	logic [SQ_W-1:0]    ps_q [3];

	logic in_acc;
	logic emit_go;
	logic [CNT_W-1:0]  k;
	logic [CIDX_W-1:0] k_last;
	logic last_c;

	logic [COORD_W-1:0] s_ch [3];
	logic [COORD_W-1:0] ca_c, cb_c, diff;
	logic [SQ_W-1:0]    sq;
	logic [D2_W-1:0]    acc_nx;

	logic              mem_we;
	logic [SIDX_W-1:0] mem_waddr;
	logic [MEM_W-1:0]  mem_wdata;
	logic [MEM_W-1:0]  mem_rd;
	logic [CIDX_W-1:0] mem_m;
	logic [CIDX_W-1:0] mem_best;
	logic [MAX_CENTERS-1:0][DIST_W-1:0] mem_row;
	logic [MAX_CENTERS-1:0][DIST_W-1:0] clr_row;

	logic [DIST_W-1:0] pair_rd;
	logic              pair_we;

	logic              sq_start;
	isqrt_stat_t       sq_stat;
	logic              better;
	logic              skip;

	logic [1:0]        mi_m1;
	logic [D2_W-1:0]   opa;
	logic [WD_W-1:0]   prod;

	logic [CIDX_W-1:0] acc_addr;
	logic [OBJ_W-1:0]  obj_nx;
	logic [DIST_W-1:0] lo_fin;
	out_word_t         exec_res;
	out_word_t         acc_res;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	always_comb begin
		if (active_q == '0) begin
			k = CNT_W'(1);
		end else if (active_q > ACT_W'(MAX_CENTERS)) begin
			k = CNT_W'(MAX_CENTERS);
		end else begin
			k = CNT_W'(active_q);
		end
	end
	assign k_last = CIDX_W'(k - 1'b1);
	assign last_c = (c_q == k_last);

	// squared distance, one channel a cycle
	assign s_ch[0] = in_q.coord_r;
	assign s_ch[1] = in_q.coord_g;
	assign s_ch[2] = in_q.coord_b;
	assign ca_c    = s_ch[ch_q];
	assign cb_c    = center_q[c_q][ch_q];
	assign diff    = (ca_c >= cb_c) ? ca_c - cb_c : cb_c - ca_c;
	assign sq      = diff * diff;
	assign acc_nx  = ((ch_q == 2'd0) ? '0 : acc_q) + D2_W'(sq);

	// sample store: membership over the lower-bound row
	assign mem_m   = mem_rd[ROW_W +: CIDX_W];
	assign mem_row = mem_rd[ROW_W-1:0];
	assign mem_best = (CNT_W'(mem_m) < k) ? mem_m : '0;

	always_comb begin
		for (int j = 0; j < MAX_CENTERS; j++) begin
			clr_row[j] = (CNT_W'(j) < k) ? '0 : mem_row[j];
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = in_q.sidx;
		mem_wdata = {best_q, row_q};
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_ROW: begin
				mem_we    = (in_q.weight == '0);
				mem_wdata = {{CIDX_W{1'b0}}, clr_row};
			end
			S_ACC: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	kea_ram #(.WIDTH(MEM_W), .DEPTH(MAX_SAMPLES)) u_row_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (in_q.sidx),
		.rdata (mem_rd)
	);

	assign pair_we = (state_q == S_EXEC) && (in_q.func == FN_PAIR);

	kea_ram #(.WIDTH(DIST_W), .DEPTH(MAX_CENTERS * MAX_CENTERS)) u_pair_ram (
		.clk   (clk),
		.we    (pair_we),
		.waddr ({in_q.center_a, in_q.center_b}),
		.wdata (in_q.hdist),
		.raddr ({best_q, c_q}),
		.rdata (pair_rd)
	);

	assign sq_start = (state_q == S_SQST);

	kea_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (d2_q),
		.stat   (sq_stat)
	);

	assign better = d2_q < best_d2_q;
	assign skip   = (c_q == best_q) || (upper_q <= row_q[c_q]) || (upper_q <= pair_rd);

	// weight products, one a cycle on a shared multiplier
	assign mi_m1 = mi_q - 2'd1;
	assign opa   = (mi_q == 2'd0) ? best_d2_q : D2_W'(s_ch[mi_m1]);
	assign prod  = WD_W'(opa) * WD_W'(in_q.weight);

	assign acc_addr = (state_q == S_ACC) ? best_q : in_q.center_a;
	assign obj_nx   = objective_q + OBJ_W'(wd_q);
	assign lo_fin   = ((k < CNT_W'(2)) || lower_q[DIST_W]) ? upper_q : lower_q[DIST_W-1:0];

	always_comb begin
		exec_res = '0;
		exec_res.objective = (in_q.func == FN_START) ? '0 : objective_q;
		if (in_q.func == FN_READ) begin
			exec_res.cluster_weight = cw_q[acc_addr];
			exec_res.cluster_sum_r  = sum_q[acc_addr][0];
			exec_res.cluster_sum_g  = sum_q[acc_addr][1];
			exec_res.cluster_sum_b  = sum_q[acc_addr][2];
		end
	end

	always_comb begin
		acc_res = '0;
		acc_res.membership        = best_q;
		acc_res.upper_bound       = upper_q;
		acc_res.lower_bound       = lo_fin;
		acc_res.weighted_distance = wd_q;
		acc_res.objective         = obj_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			active_q    <= ACT_W'(MAX_CENTERS);
			c_q         <= '0;
			best_q      <= '0;
			ch_q        <= '0;
			mi_q        <= '0;
			first_q     <= 1'b0;
			upper_q     <= '0;
			lower_q     <= '0;
			objective_q <= '0;
			for (int i = 0; i < MAX_CENTERS; i++) begin
				cw_q[i] <= '0;
				for (int h = 0; h < 3; h++) begin
					sum_q[i][h] <= '0;
				end
			end
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SIDX_W'(MAX_SAMPLES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= (in_q.func == FN_ASSIGN) ? S_ROW : S_EMIT;
					if (in_q.func == FN_START) begin
						objective_q <= '0;
						for (int i = 0; i < MAX_CENTERS; i++) begin
							cw_q[i] <= '0;
							for (int h = 0; h < 3; h++) begin
								sum_q[i][h] <= '0;
							end
						end
					end
				end
				S_ROW: begin
					if (in_q.weight == '0) begin
						state_q <= S_EMIT;
					end else begin
						best_q  <= mem_best;
						c_q     <= mem_best;
						ch_q    <= '0;
						first_q <= 1'b1;
						state_q <= S_DIST;
					end
				end
				S_DIST: begin
					ch_q <= ch_q + 1'b1;
					if (ch_q == 2'd2) begin
						state_q <= S_SQST;
					end
				end
				S_SQST: begin
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (sq_stat.done) begin
						first_q <= 1'b0;
						if (first_q) begin
							upper_q <= sq_stat.root;
							c_q     <= '0;
							lower_q <= '1;
							state_q <= (sq_stat.root > minh_q[best_q]) ? S_PAIR : S_LOW;
						end else begin
							if (better) begin
								best_q  <= c_q;
								upper_q <= sq_stat.root;
							end
							if (last_c) begin
								c_q     <= '0;
								lower_q <= '1;
								state_q <= S_LOW;
							end else begin
								c_q     <= c_q + 1'b1;
								state_q <= S_PAIR;
							end
						end
					end
				end
				S_PAIR: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (!skip) begin
						ch_q    <= '0;
						state_q <= S_DIST;
					end else if (last_c) begin
						c_q     <= '0;
						lower_q <= '1;
						state_q <= S_LOW;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= S_PAIR;
					end
				end
				S_LOW: begin
					if ((c_q != best_q) && ({1'b0, row_q[c_q]} < lower_q)) begin
						lower_q <= {1'b0, row_q[c_q]};
					end
					if (last_c) begin
						mi_q    <= '0;
						state_q <= S_MUL;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				S_MUL: begin
					mi_q <= mi_q + 1'b1;
					if (mi_q == 2'd3) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					objective_q  <= obj_nx;
					cw_q[acc_addr] <= cw_q[acc_addr] + CWT_W'(in_q.weight);
					for (int h = 0; h < 3; h++) begin
						sum_q[acc_addr][h] <= sum_q[acc_addr][h] + SUM_W'(ps_q[h]);
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_q <= in_word;
		end
		if (emit_go) begin
			out_word_q <= res_q;
		end
		case (state_q)
			S_EXEC: begin
				res_q <= exec_res;
				if (in_q.func == FN_CENTER) begin
					center_q[in_q.center_a][0] <= in_q.coord_r;
					center_q[in_q.center_a][1] <= in_q.coord_g;
					center_q[in_q.center_a][2] <= in_q.coord_b;
				end
				if (in_q.func == FN_MINHALF) begin
					minh_q[in_q.center_a] <= in_q.hdist;
				end
			end
			S_ROW: begin
				row_q <= mem_row;
			end
			S_DIST: begin
				if (ch_q == 2'd2) begin
					d2_q <= acc_nx;
				end else begin
					acc_q <= acc_nx;
				end
			end
			S_SQRT: begin
				if (sq_stat.done) begin
					if (first_q) begin
						best_d2_q      <= d2_q;
						row_q[best_q]  <= sq_stat.root;
					end else begin
						row_q[c_q] <= sq_stat.root;
						if (better) begin
							best_d2_q <= d2_q;
						end
					end
				end
			end
			S_MUL: begin
				if (mi_q == 2'd0) begin
					wd_q <= prod;
				end else begin
					ps_q[mi_m1] <= prod[SQ_W-1:0];
				end
			end
			S_ACC: begin
				res_q <= acc_res;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/kea_chk.sv
`default_nettype none
module kea_chk import kea_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire in_word_t         in_word,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire out_word_t        out_word,
	input wire logic             cfg_we,
	input wire logic [ACT_W-1:0] cfg_wdata
);

	// one command in flight: stall right after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a command is in flight");

	// cluster sums only come from a read, distances only from an assign
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.cluster_weight != '0) |->
			(out_word.weighted_distance == '0) && (out_word.upper_bound == '0))
		else $error("read result carries assign fields");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_word))
		else $error("stalled result changed");

endmodule

bind kmeans_elkan_assign kea_chk u_kea_chk (.*);
`default_nettype wire
